[rtl/rags_pkg.sv]
// Shared constants, register codes and command types of the rotation angle grid search.
package rags_pkg;

	localparam int NUM_ANGLES_DEF = 180;
	localparam int SAMPLE_W       = 24;
	localparam int ANGLE_W        = 8;
	localparam int COEF_W         = 16;
	localparam int PROD_W         = COEF_W + SAMPLE_W;
	localparam int COMP_W         = PROD_W + 1;
	localparam int ROUND_SHIFT    = 15;
	localparam int RES_W          = COMP_W - ROUND_SHIFT;
	localparam int MAG_W          = RES_W - 1;
	localparam int METRIC_W       = 2 * MAG_W;
	localparam int SUM_W          = 64;
	localparam int DEG_SPAN       = 180;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Cycles between the last angle issued and the best index being final.
	localparam int PIPE_DRAIN = 5;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_METRIC_MODE      = 1'b0,
		REG_COMPONENT_SELECT = 1'b1
	} cfg_reg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;     // write zero to the addressed accumulator
		logic load;      // capture the input sample pair
		logic issue;     // push one angle into the pipeline
		logic last;      // the item under work closes its window
		logic load_out;  // load the best angle into the result register
	} rags_cmd_t;

endpackage

[rtl/rags_in_if.sv]
// Input channel carrying one aligned pair of horizontal samples per item.
interface rags_in_if import rags_pkg::*; ();

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] x_sample;
	logic signed [SAMPLE_W-1:0] y_sample;
	logic                       last_sample;

	modport source(output valid, x_sample, y_sample, last_sample, input ready);
	modport sink(input valid, x_sample, y_sample, last_sample, output ready);

endinterface

[rtl/rags_out_if.sv]
// Output channel carrying the best rotation angle of a window per item.
interface rags_out_if import rags_pkg::*; ();

	logic               valid;
	logic               ready;
	logic [ANGLE_W-1:0] best_angle;

	modport source(output valid, best_angle, input ready);
	modport sink(input valid, best_angle, output ready);

endinterface

[rtl/rags_ctrl.sv]
// Controller state machine that sequences clearing, angle passes and result delivery.
module rags_ctrl import rags_pkg::*; #(
	parameter int NUM_ANGLES = NUM_ANGLES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_last,
	output logic                          in_ready,
	input  logic                          out_ready,
	output logic                          out_valid,
	output rags_cmd_t                     cmd,
	output logic [$clog2(NUM_ANGLES)-1:0] k_idx
);

	localparam int KW = $clog2(NUM_ANGLES);
	localparam int DW = $clog2(PIPE_DRAIN);
	localparam logic [KW-1:0] LAST_K     = KW'(NUM_ANGLES - 1);
	localparam logic [DW-1:0] DRAIN_LAST = DW'(PIPE_DRAIN - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DELIVER
	} state_t;

	state_t        state_q;
	logic [KW-1:0] k_q;
	logic [DW-1:0] drain_q;
	logic          last_q;
	logic          out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign k_idx     = k_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
			end
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				cmd.last  = last_q;
			end
			ST_DELIVER: begin
				cmd.load_out = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			k_q         <= '0;
			drain_q     <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result takes precedence over the release of the one before it.
			if (state_q == ST_DELIVER && cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (k_q == LAST_K) begin
						k_q     <= '0;
						state_q <= ST_IDLE;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						last_q  <= in_last;
						k_q     <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (k_q == LAST_K) begin
						k_q     <= '0;
						drain_q <= '0;
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				ST_DRAIN: begin
					if (drain_q == DRAIN_LAST) begin
						state_q <= last_q ? ST_DELIVER : ST_IDLE;
					end else begin
						drain_q <= drain_q + DW'(1);
					end
				end
				ST_DELIVER: begin
					if (cmd.load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/rags_datapath.sv]
// Datapath: trig tables, rotation multipliers, metric, accumulator memory and minimum search.
module rags_datapath import rags_pkg::*; #(
	parameter int NUM_ANGLES = NUM_ANGLES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_wdata,
	input  rags_cmd_t                     cmd,
	input  logic [$clog2(NUM_ANGLES)-1:0] k_idx,
	input  logic signed [SAMPLE_W-1:0]    x_in,
	input  logic signed [SAMPLE_W-1:0]    y_in,
	output logic [ANGLE_W-1:0]            best_angle
);

	localparam int KW = $clog2(NUM_ANGLES);

	// Sine of (pi/2 * num / NUM_ANGLES) in Q15 by a Taylor series in Q30.
	function automatic logic [COEF_W-1:0] quarter_sin(input logic [63:0] num);
		logic [63:0]        x;
		logic [63:0]        t;
		logic signed [63:0] acc;
		logic [63:0]        q;
		x   = (HALF_PI_Q30 * num) / NUM_ANGLES;
		t   = x;
		acc = $signed(x);
		t = (t * x) >> 30;  t = (t * x) >> 30;  t = t / 64'd6;
		acc = acc - $signed(t);
		t = (t * x) >> 30;  t = (t * x) >> 30;  t = t / 64'd20;
		acc = acc + $signed(t);
		t = (t * x) >> 30;  t = (t * x) >> 30;  t = t / 64'd42;
		acc = acc - $signed(t);
		t = (t * x) >> 30;  t = (t * x) >> 30;  t = t / 64'd72;
		acc = acc + $signed(t);
		t = (t * x) >> 30;  t = (t * x) >> 30;  t = t / 64'd110;
		acc = acc - $signed(t);
		t = (t * x) >> 30;  t = (t * x) >> 30;  t = t / 64'd156;
		acc = acc + $signed(t);
		t = (t * x) >> 30;  t = (t * x) >> 30;  t = t / 64'd210;
		acc = acc - $signed(t);
		if (acc < 0) begin
			acc = '0;
		end
		q = (64'(acc) + 64'd16384) >> 15;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		return q[COEF_W-1:0];
	endfunction

	function automatic logic signed [COEF_W-1:0] cos_val(input int k);
		logic [63:0]       twok;
		logic [63:0]       n;
		logic [COEF_W-1:0] q;
		twok = 64'(2 * k);
		n    = 64'(NUM_ANGLES);
		if (twok <= n) begin
			q = quarter_sin(n - twok);
			return $signed(q);
		end
		q = quarter_sin(twok - n);
		return COEF_W'(-$signed(q));
	endfunction

	function automatic logic signed [COEF_W-1:0] sin_val(input int k);
		logic [63:0]       twok;
		logic [63:0]       n;
		logic [COEF_W-1:0] q;
		twok = 64'(2 * k);
		n    = 64'(NUM_ANGLES);
		if (twok <= n) begin
			q = quarter_sin(twok);
		end else begin
			q = quarter_sin(2 * n - twok);
		end
		return $signed(q);
	endfunction

	logic signed [COEF_W-1:0] cos_tab [NUM_ANGLES];
	logic signed [COEF_W-1:0] sin_tab [NUM_ANGLES];
	logic [ANGLE_W-1:0]       deg_tab [NUM_ANGLES];

	for (genvar g = 0; g < NUM_ANGLES; g++) begin : g_tab
		localparam int DEG = (g * DEG_SPAN) / NUM_ANGLES;
		assign cos_tab[g] = cos_val(g);
		assign sin_tab[g] = sin_val(g);
		assign deg_tab[g] = ANGLE_W'(DEG);
	end

	// Configuration and control state.
	logic metric_q;
	logic comp_q;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic last_s1, last_s2, last_s3, last_s4, last_s5;

	// Payload.
	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [SAMPLE_W-1:0] y_q;
	logic [KW-1:0]              k_s1, k_s2, k_s3, k_s4, k_s5;
	logic signed [COEF_W-1:0]   coef_a_s1;
	logic signed [COEF_W-1:0]   coef_b_s1;
	logic signed [PROD_W-1:0]   prod_a_s2;
	logic signed [PROD_W-1:0]   prod_b_s2;
	logic [MAG_W-1:0]           mag_s3;
	logic [METRIC_W-1:0]        metric_s4;
	logic [SUM_W-1:0]           rd_s4;
	logic [SUM_W-1:0]           sum_s5;
	logic [SUM_W-1:0]           best_sum_q;
	logic [KW-1:0]              best_k_q;
	logic [ANGLE_W-1:0]         res_q;
	logic [SUM_W-1:0]           sum_mem [NUM_ANGLES];

	logic signed [COMP_W-1:0] comp_v;
	logic signed [COMP_W-1:0] comp_rnd;
	logic signed [RES_W-1:0]  comp_r;
	logic [MAG_W-1:0]         mag_c;
	logic [SUM_W:0]           sum_ext;
	logic [SUM_W-1:0]         sat_sum;

	assign comp_v   = COMP_W'(prod_a_s2) - COMP_W'(prod_b_s2);
	assign comp_rnd = comp_v + COMP_W'(16384);
	assign comp_r   = RES_W'(comp_rnd >>> ROUND_SHIFT);
	assign mag_c    = comp_r[RES_W-1] ? MAG_W'(-comp_r) : MAG_W'(comp_r);
	assign sum_ext  = {1'b0, rd_s4} + (SUM_W + 1)'(metric_s4);
	assign sat_sum  = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

	assign best_angle = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q <= 1'b0;
			comp_q   <= 1'b0;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
			vld_s5   <= 1'b0;
			last_s1  <= 1'b0;
			last_s2  <= 1'b0;
			last_s3  <= 1'b0;
			last_s4  <= 1'b0;
			last_s5  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_METRIC_MODE:      metric_q <= cfg_wdata[0];
					REG_COMPONENT_SELECT: comp_q   <= cfg_wdata[0];
					default: begin
					end
				endcase
			end
			vld_s1  <= cmd.issue;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			last_s1 <= cmd.last;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			last_s4 <= last_s3;
			last_s5 <= last_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= x_in;
			y_q <= y_in;
		end
		// Transverse: cos*x - sin*y. Radial: -sin*x - cos*y.
		k_s1      <= k_idx;
		coef_a_s1 <= comp_q ? COEF_W'(-sin_tab[k_idx]) : cos_tab[k_idx];
		coef_b_s1 <= comp_q ? cos_tab[k_idx] : sin_tab[k_idx];
		k_s2      <= k_s1;
		prod_a_s2 <= coef_a_s1 * x_q;
		prod_b_s2 <= coef_b_s1 * y_q;
		k_s3      <= k_s2;
		mag_s3    <= mag_c;
		k_s4      <= k_s3;
		metric_s4 <= metric_q ? mag_s3 * mag_s3 : METRIC_W'(mag_s3);
		k_s5      <= k_s4;
		sum_s5    <= sat_sum;
		if (vld_s5 && last_s5 && (k_s5 == '0 || sum_s5 < best_sum_q)) begin
			best_sum_q <= sum_s5;
			best_k_q   <= k_s5;
		end
		if (cmd.load_out) begin
			res_q <= deg_tab[best_k_q];
		end
	end

	// Accumulator memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			sum_mem[k_idx] <= '0;
		end else if (vld_s4) begin
			sum_mem[k_s4] <= last_s4 ? '0 : sat_sum;
		end
		rd_s4 <= sum_mem[k_s3];
	end

endmodule

[rtl/rotation_angle_grid_search_core.sv]
// The one shared rotate and accumulate datapath visits one angle per cycle, and each item
// takes a full pass over the angles plus a drain of its pipeline; an item that closes a window
// also takes a delivery step, and no new item is accepted before these are done. The result
// is valid after the closing item's drain, later only if the previous result has not been taken.
// Reset: asynchronous, active low; the control registers return to zero and a clearing pass
// over every angle zeroes the accumulators, during which no item is accepted.
module rotation_angle_grid_search_core import rags_pkg::*; #(
	parameter int NUM_ANGLES = NUM_ANGLES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rags_in_if.sink               samples,
	rags_out_if.source            result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int KW = $clog2(NUM_ANGLES);

	// The controller walks the trial angles once per item and tells the datapath
	// what to do each cycle. The datapath needs nothing back: every latency in it
	// is fixed, so the controller simply counts the pipeline out before it either
	// returns to idle or, at the end of a window, hands the best angle to the
	// result register.
	rags_cmd_t     cmd;
	logic [KW-1:0] k_idx;

	rags_ctrl #(
		.NUM_ANGLES(NUM_ANGLES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_last  (samples.last_sample),
		.in_ready (samples.ready),
		.out_ready(result.ready),
		.out_valid(result.valid),
		.cmd      (cmd),
		.k_idx    (k_idx)
	);

	// The datapath rotates the sample pair through a Q1.15 sine and cosine
	// table, rounds the chosen component back to counts, forms its magnitude or
	// square and adds it with saturation into the angle's 64-bit accumulator.
	// On the closing item of a window each new sum is compared as it is formed,
	// the lowest index winning a tie, and the accumulator is written back as
	// zero so that the next window starts clean without a separate pass.
	rags_datapath #(
		.NUM_ANGLES(NUM_ANGLES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.k_idx     (k_idx),
		.x_in      (samples.x_sample),
		.y_in      (samples.y_sample),
		.best_angle(result.best_angle)
	);

	// An accepted item keeps the block busy for at least a full pass.
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=> !samples.ready)
		else $error("input accepted again straight after an item");

	// A reported angle always lies within the half circle.
	a_angle_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.best_angle < ANGLE_W'(DEG_SPAN)))
		else $error("best angle out of range");

	// A new result is only raised out of the delivery step, never while idle.
	a_result_from_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(!samples.ready))
		else $error("result raised while the block was idle");

endmodule
